FILE: rtl/shp_pkg.sv
package shp_pkg;

    // command codes of an input transaction
    localparam logic [1:0] CMD_ABSORB_BYTE = 2'd0;
    localparam logic [1:0] CMD_ABSORB_WORD = 2'd1;
    localparam logic [1:0] CMD_FINALIZE    = 2'd2;
    localparam logic [1:0] CMD_RESTART     = 2'd3;

    // status codes of a result transaction
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_MISALIGN = 1'b1;

    // configuration register indexes
    localparam logic CFG_KEY_FIRST  = 1'b0;
    localparam logic CFG_KEY_SECOND = 1'b1;

    // initialization constants of the four lanes
    localparam logic [63:0] INIT_LANE0 = 64'h736f6d6570736575;
    localparam logic [63:0] INIT_LANE1 = 64'h646f72616e646f6d;
    localparam logic [63:0] INIT_LANE2 = 64'h6c7967656e657261;
    localparam logic [63:0] INIT_LANE3 = 64'h7465646279746573;
    localparam logic [63:0] FINAL_XOR  = 64'h00000000000000ff;

    // depth of the queue between front and back
    localparam int unsigned OPQ_DEPTH = 4;
    localparam int unsigned OPQ_AW    = $clog2(OPQ_DEPTH);

    // depth of the result queue
    localparam int unsigned RESQ_DEPTH = 2;
    localparam int unsigned RESQ_AW    = $clog2(RESQ_DEPTH);

    // round index of the last compression round and of the last finalization round
    localparam logic [2:0] ROUND_COMPRESS_LAST = 3'd1;
    localparam logic [2:0] ROUND_FINAL_LAST    = 3'd5;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] payload;
    } t_in;

    typedef struct packed {
        logic [63:0] digest;
        logic        status;
    } t_out;

    // operations handed from the front to the back
    typedef enum logic [1:0] {
        OP_COMPRESS,
        OP_FINAL,
        OP_ERROR,
        OP_RESTART
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [63:0] word;
    } t_op_entry;

    typedef logic [3:0][63:0] t_lanes;

    // one SipRound over the four lanes
    function automatic t_lanes sip_round(input t_lanes s);
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
        t_lanes      r;
        v0 = s[0];
        v1 = s[1];
        v2 = s[2];
        v3 = s[3];
        v0 = v0 + v1;
        v1 = {v1[50:0], v1[63:51]};
        v1 = v1 ^ v0;
        v0 = {v0[31:0], v0[63:32]};
        v2 = v2 + v3;
        v3 = {v3[47:0], v3[63:48]};
        v3 = v3 ^ v2;
        v0 = v0 + v3;
        v3 = {v3[42:0], v3[63:43]};
        v3 = v3 ^ v0;
        v2 = v2 + v1;
        v1 = {v1[46:0], v1[63:47]};
        v1 = v1 ^ v2;
        v2 = {v2[31:0], v2[63:32]};
        r[0] = v0;
        r[1] = v1;
        r[2] = v2;
        r[3] = v3;
        return r;
    endfunction

endpackage

FILE: rtl/shp_front.sv
module shp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  shp_pkg::t_in        i_item,
    output logic                o_push,
    output shp_pkg::t_op_entry  o_entry
);

    logic [7:0]  r_count;
    logic [7:0]  n_count;
    logic [55:0] r_partial;
    logic [55:0] n_partial;
    logic [63:0] byte_word;
    logic [7:0]  byte_count_inc;

    // byte merged into the partial word at its little-endian place
    assign byte_word = {8'd0, r_partial}
                     | ({56'd0, i_item.payload[7:0]} << {r_count[2:0], 3'd0});
    assign byte_count_inc = r_count + 8'd1;

    // classify the transaction and advance the length state
    always_comb begin
        n_count       = r_count;
        n_partial     = r_partial;
        o_push        = 1'b0;
        o_entry.op    = shp_pkg::OP_COMPRESS;
        o_entry.word  = i_item.payload;
        if (i_accept) begin
            case (i_item.command)
                shp_pkg::CMD_ABSORB_BYTE: begin
                    n_count      = byte_count_inc;
                    o_entry.word = byte_word;
                    if (byte_count_inc[2:0] == 3'd0) begin
                        o_push    = 1'b1;
                        n_partial = '0;
                    end else begin
                        n_partial = byte_word[55:0];
                    end
                end
                shp_pkg::CMD_ABSORB_WORD: begin
                    o_push = 1'b1;
                    if (r_count[2:0] != 3'd0) begin
                        o_entry.op = shp_pkg::OP_ERROR;
                    end else begin
                        n_count = r_count + 8'd8;
                    end
                end
                shp_pkg::CMD_FINALIZE: begin
                    o_push       = 1'b1;
                    o_entry.op   = shp_pkg::OP_FINAL;
                    o_entry.word = {r_count, r_partial};
                end
                default: begin
                    o_push     = 1'b1;
                    o_entry.op = shp_pkg::OP_RESTART;
                    n_count    = '0;
                    n_partial  = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_partial <= '0;
        end else begin
            r_count   <= n_count;
            r_partial <= n_partial;
        end
    end

endmodule

FILE: rtl/shp_op_queue.sv
module shp_op_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  shp_pkg::t_op_entry  i_entry,
    input  logic                i_pop,
    output shp_pkg::t_op_entry  o_entry,
    output logic                o_empty,
    output logic                o_full
);

    shp_pkg::t_op_entry r_mem [shp_pkg::OPQ_DEPTH];
    logic [shp_pkg::OPQ_AW-1:0] r_wr_ptr;
    logic [shp_pkg::OPQ_AW-1:0] r_rd_ptr;
    logic [shp_pkg::OPQ_AW:0]   r_level;
    logic                       do_push;
    logic                       do_pop;

    assign o_empty = (r_level == '0);
    assign o_full  = (r_level == (shp_pkg::OPQ_AW + 1)'(shp_pkg::OPQ_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_entry = r_mem[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_level <= r_level + 1'b1;
            end else if (do_pop && !do_push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

FILE: rtl/shp_back.sv
module shp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [63:0]         i_key_first,
    input  logic [63:0]         i_key_second,
    input  shp_pkg::t_op_entry  i_entry,
    input  logic                i_op_empty,
    output logic                o_op_pop,
    input  logic                i_res_pop,
    output logic                o_res_empty,
    output shp_pkg::t_out       o_result
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state              r_state;
    logic [2:0]          r_round;
    shp_pkg::t_op        r_op;
    logic [63:0]         r_m;
    shp_pkg::t_lanes     r_w;
    shp_pkg::t_lanes     r_lanes;
    shp_pkg::t_lanes     start_in;
    shp_pkg::t_lanes     start_round;
    shp_pkg::t_lanes     run_round;
    shp_pkg::t_lanes     key_lanes;
    shp_pkg::t_lanes     mixed_lanes;
    shp_pkg::t_lanes     final_lanes;

    shp_pkg::t_out               r_res_mem [shp_pkg::RESQ_DEPTH];
    logic [shp_pkg::RESQ_AW-1:0] r_res_wr;
    logic [shp_pkg::RESQ_AW-1:0] r_res_rd;
    logic [shp_pkg::RESQ_AW:0]   r_res_level;
    logic                        res_full;
    logic                        res_push;
    logic                        res_pop;
    shp_pkg::t_out               res_data;
    logic                        needs_slot;

    // round logic: first round straight from the lanes, later rounds from the work copy
    always_comb begin
        start_in    = r_lanes;
        start_in[3] = r_lanes[3] ^ i_entry.word;
        start_round = shp_pkg::sip_round(start_in);
        run_round   = shp_pkg::sip_round(r_w);
        key_lanes[0] = shp_pkg::INIT_LANE0 ^ i_key_first;
        key_lanes[1] = shp_pkg::INIT_LANE1 ^ i_key_second;
        key_lanes[2] = shp_pkg::INIT_LANE2 ^ i_key_first;
        key_lanes[3] = shp_pkg::INIT_LANE3 ^ i_key_second;
        // end of compression: message into lane zero, finalization constant into lane two
        mixed_lanes    = run_round;
        mixed_lanes[0] = run_round[0] ^ r_m;
        final_lanes    = mixed_lanes;
        final_lanes[2] = run_round[2] ^ shp_pkg::FINAL_XOR;
    end

    // take an operation when idle; result-producing ones need a free result slot
    assign res_full   = (r_res_level == (shp_pkg::RESQ_AW + 1)'(shp_pkg::RESQ_DEPTH));
    assign needs_slot = (i_entry.op == shp_pkg::OP_ERROR) || (i_entry.op == shp_pkg::OP_FINAL);
    assign o_op_pop   = (r_state == ST_IDLE) && !i_op_empty && !(needs_slot && res_full);

    // result queue write side
    always_comb begin
        res_push        = 1'b0;
        res_data.digest = run_round[0] ^ run_round[1] ^ run_round[2] ^ run_round[3];
        res_data.status = shp_pkg::STATUS_OK;
        if (o_op_pop && (i_entry.op == shp_pkg::OP_ERROR)) begin
            res_push        = 1'b1;
            res_data.digest = '0;
            res_data.status = shp_pkg::STATUS_MISALIGN;
        end else if ((r_state == ST_RUN) && (r_round == shp_pkg::ROUND_FINAL_LAST)) begin
            res_push = 1'b1;
        end
    end

    // sequencer and lane state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_round <= '0;
            r_lanes[0] <= shp_pkg::INIT_LANE0;
            r_lanes[1] <= shp_pkg::INIT_LANE1;
            r_lanes[2] <= shp_pkg::INIT_LANE2;
            r_lanes[3] <= shp_pkg::INIT_LANE3;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (o_op_pop) begin
                        case (i_entry.op)
                            shp_pkg::OP_COMPRESS,
                            shp_pkg::OP_FINAL: begin
                                r_state <= ST_RUN;
                                r_round <= 3'd1;
                            end
                            shp_pkg::OP_RESTART: begin
                                r_lanes <= key_lanes;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_RUN: begin
                    if (r_round == shp_pkg::ROUND_COMPRESS_LAST) begin
                        if (r_op == shp_pkg::OP_COMPRESS) begin
                            r_lanes <= mixed_lanes;
                            r_state <= ST_IDLE;
                        end else begin
                            r_round <= r_round + 3'd1;
                        end
                    end else if (r_round == shp_pkg::ROUND_FINAL_LAST) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_round <= r_round + 3'd1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // work copy of the lanes and the operation under way
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && o_op_pop) begin
            r_op <= i_entry.op;
            r_m  <= i_entry.word;
            r_w  <= start_round;
        end else if (r_state == ST_RUN) begin
            if (r_round == shp_pkg::ROUND_COMPRESS_LAST) begin
                r_w <= final_lanes;
            end else begin
                r_w <= run_round;
            end
        end
    end

    // result queue
    assign o_res_empty = (r_res_level == '0);
    assign res_pop     = i_res_pop && !o_res_empty;
    assign o_result    = r_res_mem[r_res_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_wr    <= '0;
            r_res_rd    <= '0;
            r_res_level <= '0;
        end else begin
            if (res_push) begin
                r_res_wr <= r_res_wr + 1'b1;
            end
            if (res_pop) begin
                r_res_rd <= r_res_rd + 1'b1;
            end
            if (res_push && !res_pop) begin
                r_res_level <= r_res_level + 1'b1;
            end else if (res_pop && !res_push) begin
                r_res_level <= r_res_level - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_res_mem[r_res_wr] <= res_data;
        end
    end

endmodule

FILE: rtl/siphash_2_4_stream_hasher.sv
// Keyed SipHash-2-4 over a stream of commands.
// Input channel: an item (command, payload) is taken at a clock edge with push high and
// full low. Result channel: while empty is low the oldest result (digest, status) is on
// o_result; it is taken at an edge with pop high. Keys are written on the i_cfg_* port and
// take effect at the next restart command; the user must write them only while the
// block is idle, which the block itself does not enforce. Throughput: one item per cycle
// for absorb-byte commands while full is low. The back end runs one SipRound per cycle:
// a word compression holds it for its compression rounds, a finalize for those of the
// final block and the finalization rounds; a restart or misaligned-word error is handled
// as it is taken. A 4-entry operation queue sits between the classifying front end and
// the round unit, so bytes keep flowing while a compression runs; aligned words are taken
// while the queue has room, and the back end starts each once the one before is done.
// Reset (synchronous, active low) clears keys to zero, loads the lanes with the
// initialization constants and empties both queues.
// When the receiver stalls, results wait in a 2-entry result queue; once it is full the
// round unit holds further result-producing operations, the operation queue fills and
// full rises.
module siphash_2_4_stream_hasher (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  shp_pkg::t_in   i_item,
    output logic           empty,
    input  logic           pop,
    output shp_pkg::t_out  o_result,
    input  logic           i_cfg_wen,
    input  logic           i_cfg_idx,
    input  logic [63:0]    i_cfg_data
);

    logic [63:0]        r_key_first;
    logic [63:0]        r_key_second;
    logic               accept;
    logic               fe_push;
    shp_pkg::t_op_entry fe_entry;
    shp_pkg::t_op_entry q_entry;
    logic               q_empty;
    logic               q_pop;

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_first  <= '0;
            r_key_second <= '0;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                shp_pkg::CFG_KEY_FIRST:  r_key_first  <= i_cfg_data;
                shp_pkg::CFG_KEY_SECOND: r_key_second <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign accept = push && !full;

    // front end: length tracking and classification
    shp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_push   (fe_push),
        .o_entry  (fe_entry)
    );

    // operation queue between front and back
    shp_op_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_entry (fe_entry),
        .i_pop   (q_pop),
        .o_entry (q_entry),
        .o_empty (q_empty),
        .o_full  (full)
    );

    // back end: round unit, lanes and result queue
    shp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key_first  (r_key_first),
        .i_key_second (r_key_second),
        .i_entry      (q_entry),
        .i_op_empty   (q_empty),
        .o_op_pop     (q_pop),
        .i_res_pop    (pop),
        .o_res_empty  (empty),
        .o_result     (o_result)
    );

endmodule

FILE: rtl/shp_checker.sv
module shp_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    input  logic           full,
    input  logic           empty,
    input  logic           pop,
    input  shp_pkg::t_out  o_result
);

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending after reset");

    // reset leaves room for input
    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input blocked after reset");

    // an error result carries a zero digest
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result.status == shp_pkg::STATUS_MISALIGN)) |-> (o_result.digest == '0))
        else $error("error result with nonzero digest");

    // a result not taken stays put
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("pending result changed while stalled");

    // a push against a full queue is held until taken
    a_push_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && full) |=> push)
        else $error("push dropped while full");

endmodule

bind siphash_2_4_stream_hasher shp_checker u_shp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);
